FILE: hw/rtl/thick_line_rasterizer_core_macros.svh
// Assertion macros shared by the rasterizer RTL.
`ifndef THICK_LINE_RASTERIZER_CORE_MACROS_SVH
`define THICK_LINE_RASTERIZER_CORE_MACROS_SVH

// Clocked check, off while reset is high.
`define TLR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds through reset.
`define TLR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/tlr_pkg.sv
// Package with widths, register indexes and opcodes of the thick line rasterizer.
package tlr_pkg;

   localparam int COORD_BITS    = 16;
   localparam int WIDE_BITS     = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
   localparam int ERR_BITS      = COORD_BITS + 3;
   localparam int STEP_BITS     = COORD_BITS + 1;
   localparam int DIM_BITS      = 15;
   localparam int STRIDE_BITS   = 16;
   localparam int HEIGHT_BITS   = 8;
   localparam int COLOR_BITS    = 32;
   localparam int ADDR_BITS     = 32;
   localparam int PROD_BITS     = DIM_BITS + STRIDE_BITS;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [DIM_BITS-1:0]    FRAME_WIDTH_RESET  = DIM_BITS'(1920);
   localparam logic [DIM_BITS-1:0]    FRAME_HEIGHT_RESET = DIM_BITS'(1080);
   localparam logic [STRIDE_BITS-1:0] ROW_STRIDE_RESET   = STRIDE_BITS'(1920);
   localparam logic [HEIGHT_BITS-1:0] LINE_HEIGHT_RESET  = HEIGHT_BITS'(1);

   localparam logic signed [WIDE_BITS-1:0]  WIDE_ONE  = WIDE_BITS'(1);
   localparam logic signed [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);
   localparam logic [STEP_BITS-1:0]         STEP_ONE  = STEP_BITS'(1);

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_ROW_STRIDE   = 2'd2,
      REG_LINE_HEIGHT  = 2'd3
   } csr_reg_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } opcode_type;

endpackage

FILE: hw/rtl/thick_line_rasterizer_core.sv
// Thick line rasterizer: Bresenham stepper emitting clipped vertical spans.
//
//   channel | direction | handshake          | transaction
//   req     | in        | req_valid/req_stall | load line (opcode 0) or step (opcode 1)
//   rsp     | out       | rsp_valid/rsp_stall | one span per step, none per load
//   csr     | in/out    | APB psel/penable    | 32-bit register write or read
//
// One transaction per cycle on req unless stalled; a step's span is registered when accepted.
// Path per step: clip compare, one 15x16 address multiply and an add, all from the state regs.
// req_stall is high only while a span sits in the output register and rsp_stall is high.
// Synchronous reset clears the line state and loads the register defaults; no line is active.
`include "thick_line_rasterizer_core_macros.svh"

module thick_line_rasterizer_core import tlr_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic signed [COORD_BITS-1:0]  req_x_start,
   input  logic signed [COORD_BITS-1:0]  req_y_start,
   input  logic signed [COORD_BITS-1:0]  req_x_end,
   input  logic signed [COORD_BITS-1:0]  req_y_end,
   input  logic [COLOR_BITS-1:0]         req_draw_color,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [DIM_BITS-1:0]           rsp_pixel_x,
   output logic [DIM_BITS-1:0]           rsp_row_first,
   output logic [DIM_BITS-1:0]           rsp_row_last,
   output logic [ADDR_BITS-1:0]          rsp_first_address,
   output logic [COLOR_BITS-1:0]         rsp_span_color,
   output logic                          rsp_visible,
   output logic                          rsp_line_done,

   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                          csr_pready
);

   // configuration
   logic [DIM_BITS-1:0]    frame_width_ff, frame_height_ff;
   logic [STRIDE_BITS-1:0] row_stride_ff;
   logic [HEIGHT_BITS-1:0] line_height_ff;
   logic                   csr_write;
   csr_reg_type            csr_index;

   // line state
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]        delta_x_ff, delta_x_in, delta_y_ff, delta_y_in;
   logic signed [ERR_BITS-1:0]   error_ff, error_in;
   logic                         dir_x_neg_ff, dir_x_neg_in, dir_y_neg_ff, dir_y_neg_in;
   logic                         x_is_major_ff, x_is_major_in;
   logic [STEP_BITS-1:0]         steps_left_ff, steps_left_in;
   logic                         line_active_ff, line_active_in;
   logic [COLOR_BITS-1:0]        held_color_ff, held_color_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DIM_BITS-1:0]    pixel_x_ff, pixel_x_in, row_first_ff, row_first_in;
   logic [DIM_BITS-1:0]    row_last_ff, row_last_in;
   logic [ADDR_BITS-1:0]   address_ff, address_in;
   logic [COLOR_BITS-1:0]  color_ff, color_in;
   logic                   visible_ff, visible_in, done_ff, done_in;

   logic req_accept, is_step, active_step;

   // load datapath
   logic signed [COORD_BITS:0] diff_x, diff_y, neg_diff_x, neg_diff_y;
   logic                       x_pos, y_pos, load_x_major;
   logic [COORD_BITS-1:0]      abs_dx, abs_dy, load_major;

   // span datapath
   logic signed [WIDE_BITS-1:0] cur_x_w, cur_y_w, lh_w, fw_w, fh_last_w;
   logic signed [WIDE_BITS-1:0] bottom_w, rf_w, rl_w;
   logic                        x_inside, span_vis;
   logic [DIM_BITS-1:0]         span_x;
   logic [PROD_BITS-1:0]        row_product;

   // step datapath
   logic [COORD_BITS-1:0]      maj_delta, min_delta;
   logic signed [ERR_BITS-1:0] twice_maj, twice_min, err_add;
   logic                       minor_move, x_moves, y_moves;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_reg_type'(csr_paddr[3:2]);

   always_comb begin
      unique case (csr_index)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_BITS'(frame_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_BITS'(frame_height_ff);
         REG_ROW_STRIDE:   csr_prdata = CSR_DATA_BITS'(row_stride_ff);
         REG_LINE_HEIGHT:  csr_prdata = CSR_DATA_BITS'(line_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         row_stride_ff   <= ROW_STRIDE_RESET;
         line_height_ff  <= LINE_HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_pwdata[DIM_BITS-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_pwdata[DIM_BITS-1:0];
            REG_ROW_STRIDE:   row_stride_ff   <= csr_pwdata[STRIDE_BITS-1:0];
            REG_LINE_HEIGHT:  line_height_ff  <= csr_pwdata[HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- handshake ----------------
   assign req_stall   = rsp_valid_ff && rsp_stall;
   assign req_accept  = req_valid && !req_stall;
   assign is_step     = opcode_type'(req_opcode) == OP_STEP;
   assign active_step = line_active_ff && (steps_left_ff != '0);

   // ---------------- load ----------------
   assign diff_x     = (COORD_BITS+1)'(req_x_end) - (COORD_BITS+1)'(req_x_start);
   assign diff_y     = (COORD_BITS+1)'(req_y_end) - (COORD_BITS+1)'(req_y_start);
   assign neg_diff_x = -diff_x;
   assign neg_diff_y = -diff_y;
   assign x_pos      = !diff_x[COORD_BITS] && (diff_x != '0);
   assign y_pos      = !diff_y[COORD_BITS] && (diff_y != '0);
   assign abs_dx     = x_pos ? diff_x[COORD_BITS-1:0] : neg_diff_x[COORD_BITS-1:0];
   assign abs_dy     = y_pos ? diff_y[COORD_BITS-1:0] : neg_diff_y[COORD_BITS-1:0];
   assign load_x_major = abs_dx >= abs_dy;
   assign load_major   = load_x_major ? abs_dx : abs_dy;

   // ---------------- span of the current point ----------------
   assign cur_x_w   = WIDE_BITS'(cur_x_ff);
   assign cur_y_w   = WIDE_BITS'(cur_y_ff);
   assign lh_w      = signed'(WIDE_BITS'(line_height_ff));
   assign fw_w      = signed'(WIDE_BITS'(frame_width_ff));
   assign fh_last_w = signed'(WIDE_BITS'(frame_height_ff)) - WIDE_ONE;
   assign bottom_w  = cur_y_w + lh_w - WIDE_ONE;
   assign rf_w      = cur_y_w[WIDE_BITS-1] ? '0 : cur_y_w;
   assign rl_w      = (bottom_w > fh_last_w) ? fh_last_w : bottom_w;
   assign x_inside  = !cur_x_w[WIDE_BITS-1] && (cur_x_w < fw_w);
   assign span_vis  = active_step && (line_height_ff != '0) && x_inside && (rf_w <= rl_w);
   assign span_x    = DIM_BITS'(cur_x_ff);
   assign row_product = PROD_BITS'(rf_w[DIM_BITS-1:0]) * PROD_BITS'(row_stride_ff);

   // ---------------- Bresenham advance ----------------
   assign maj_delta  = x_is_major_ff ? delta_x_ff : delta_y_ff;
   assign min_delta  = x_is_major_ff ? delta_y_ff : delta_x_ff;
   assign twice_maj  = signed'(ERR_BITS'({maj_delta, 1'b0}));
   assign twice_min  = signed'(ERR_BITS'({min_delta, 1'b0}));
   assign err_add    = error_ff + twice_min;
   assign minor_move = !err_add[ERR_BITS-1];
   assign x_moves    = x_is_major_ff || minor_move;
   assign y_moves    = !x_is_major_ff || minor_move;

   always_comb begin
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      delta_x_in     = delta_x_ff;
      delta_y_in     = delta_y_ff;
      error_in       = error_ff;
      dir_x_neg_in   = dir_x_neg_ff;
      dir_y_neg_in   = dir_y_neg_ff;
      x_is_major_in  = x_is_major_ff;
      steps_left_in  = steps_left_ff;
      line_active_in = line_active_ff;
      held_color_in  = held_color_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pixel_x_in   = pixel_x_ff;
      row_first_in = row_first_ff;
      row_last_in  = row_last_ff;
      address_in   = address_ff;
      color_in     = color_ff;
      visible_in   = visible_ff;
      done_in      = done_ff;

      if (req_accept && !is_step) begin
         cur_x_in       = req_x_start;
         cur_y_in       = req_y_start;
         delta_x_in     = abs_dx;
         delta_y_in     = abs_dy;
         dir_x_neg_in   = !x_pos;
         dir_y_neg_in   = !y_pos;
         x_is_major_in  = load_x_major;
         error_in       = -signed'(ERR_BITS'(load_major));
         steps_left_in  = STEP_BITS'(load_major) + STEP_ONE;
         line_active_in = 1'b1;
         held_color_in  = req_draw_color;
      end else if (req_accept && is_step) begin
         rsp_valid_in = 1'b1;
         pixel_x_in   = span_vis ? span_x : '0;
         row_first_in = span_vis ? rf_w[DIM_BITS-1:0] : '0;
         row_last_in  = span_vis ? rl_w[DIM_BITS-1:0] : '0;
         address_in   = span_vis ? ADDR_BITS'(row_product) + ADDR_BITS'(span_x) : '0;
         visible_in   = span_vis;
         color_in     = active_step ? held_color_ff : '0;
         done_in      = active_step ? (steps_left_ff == STEP_ONE) : 1'b1;
         if (active_step) begin
            if (x_moves) begin
               cur_x_in = dir_x_neg_ff ? cur_x_ff - COORD_ONE : cur_x_ff + COORD_ONE;
            end
            if (y_moves) begin
               cur_y_in = dir_y_neg_ff ? cur_y_ff - COORD_ONE : cur_y_ff + COORD_ONE;
            end
            error_in       = minor_move ? err_add - twice_maj : err_add;
            steps_left_in  = steps_left_ff - STEP_ONE;
            line_active_in = steps_left_ff != STEP_ONE;
         end else begin
            line_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         delta_x_ff     <= '0;
         delta_y_ff     <= '0;
         error_ff       <= '0;
         dir_x_neg_ff   <= 1'b0;
         dir_y_neg_ff   <= 1'b0;
         x_is_major_ff  <= 1'b0;
         steps_left_ff  <= '0;
         line_active_ff <= 1'b0;
         held_color_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         delta_x_ff     <= delta_x_in;
         delta_y_ff     <= delta_y_in;
         error_ff       <= error_in;
         dir_x_neg_ff   <= dir_x_neg_in;
         dir_y_neg_ff   <= dir_y_neg_in;
         x_is_major_ff  <= x_is_major_in;
         steps_left_ff  <= steps_left_in;
         line_active_ff <= line_active_in;
         held_color_ff  <= held_color_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_x_ff   <= pixel_x_in;
      row_first_ff <= row_first_in;
      row_last_ff  <= row_last_in;
      address_ff   <= address_in;
      color_ff     <= color_in;
      visible_ff   <= visible_in;
      done_ff      <= done_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_x       = pixel_x_ff;
   assign rsp_row_first     = row_first_ff;
   assign rsp_row_last      = row_last_ff;
   assign rsp_first_address = address_ff;
   assign rsp_span_color    = color_ff;
   assign rsp_visible       = visible_ff;
   assign rsp_line_done     = done_ff;

   // ---------------- assertions ----------------
   `TLR_ASSERT(a_active_has_steps, line_active_ff |-> (steps_left_ff != '0), "active line with no steps left")
   `TLR_ASSERT(a_rows_ordered, (rsp_valid_ff && visible_ff) |-> (row_first_ff <= row_last_ff), "visible span rows out of order")
   `TLR_ASSERT(a_hidden_zero, (rsp_valid_ff && !visible_ff) |-> (address_ff == '0 && pixel_x_ff == '0), "hidden span carries position")
   `TLR_ASSERT(a_idle_step_done, (req_accept && is_step && !line_active_ff) |=> (rsp_valid_ff && done_ff), "step without line not flagged done")

endmodule

FILE: sim/thick_line_rasterizer_core_tb.sv
// Self-checking testbench for the thick line rasterizer core: directed table, then random phases.
module thick_line_rasterizer_core_tb;
   import tlr_pkg::*;

   typedef struct packed {
      logic [DIM_BITS-1:0]   pixel_x;
      logic [DIM_BITS-1:0]   row_first;
      logic [DIM_BITS-1:0]   row_last;
      logic [ADDR_BITS-1:0]  first_address;
      logic [COLOR_BITS-1:0] span_color;
      logic                  visible;
      logic                  line_done;
   } span_type;

   typedef struct packed {
      opcode_type              opcode;
      logic [COORD_BITS-1:0]   x_start;
      logic [COORD_BITS-1:0]   y_start;
      logic [COORD_BITS-1:0]   x_end;
      logic [COORD_BITS-1:0]   y_end;
      logic [COLOR_BITS-1:0]   draw_color;
      logic                    typed;
      span_type                want;
   } stim_row_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   localparam span_type NO_SPAN   = '0;
   localparam span_type DONE_ONLY = '{15'd0, 15'd0, 15'd0, 32'd0, 32'd0, 1'b0, 1'b1};
   localparam int    DIRECTED_ROWS    = 26;
   localparam int    RANDOM_PHASES    = 7;
   localparam int    FIXED_PHASES     = 5;
   localparam int    RANDOM_PER_PHASE = 86;
   localparam int    DRAIN_CYCLES     = 8;
   localparam int    CYCLE_LIMIT      = 300000;
   localparam int    PRINT_LIMIT      = 40;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_opcode = 1'b0;
   logic signed [COORD_BITS-1:0] req_x_start = '0;
   logic signed [COORD_BITS-1:0] req_y_start = '0;
   logic signed [COORD_BITS-1:0] req_x_end = '0;
   logic signed [COORD_BITS-1:0] req_y_end = '0;
   logic [COLOR_BITS-1:0]        req_draw_color = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [DIM_BITS-1:0]          rsp_pixel_x;
   logic [DIM_BITS-1:0]          rsp_row_first;
   logic [DIM_BITS-1:0]          rsp_row_last;
   logic [ADDR_BITS-1:0]         rsp_first_address;
   logic [COLOR_BITS-1:0]        rsp_span_color;
   logic                         rsp_visible;
   logic                         rsp_line_done;
   logic                         csr_psel = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]     csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]     csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0]     csr_prdata;
   logic                         csr_pready;

   // rasterizer state mirror
   int          cfg_width = 1920;
   int          cfg_height = 1080;
   int          cfg_stride = 1920;
   int          cfg_thickness = 1;
   int          pos_x = 0;
   int          pos_y = 0;
   int          run_x = 0;
   int          run_y = 0;
   int          err_acc = 0;
   bit          x_backward = 1'b0;
   bit          y_backward = 1'b0;
   bit          x_major = 1'b0;
   int          pixels_left = 0;
   bit          line_live = 1'b0;
   logic [31:0] line_color = '0;

   span_type       span_queue[$];
   int             error_count = 0;
   int             cycle_count = 0;
   int             burst_left = 0;
   int             stall_hold = 0;
   stall_mode_type stall_mode = STALL_NONE;
   stim_row_type   directed_rows [DIRECTED_ROWS];
   int             fixed_cfg [FIXED_PHASES][4] = '{
      '{0, 0, 0, 0},
      '{32767, 32767, 65535, 255},
      '{64, 48, 100, 3},
      '{40, 30, 40, 255},
      '{1, 1, 1, 1}
   };

   thick_line_rasterizer_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("ERROR cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // Models a load or a Bresenham step with clipping; returns 1 when the transaction yields a span.
   function automatic bit rasterize_item(input stim_row_type r, output span_type s);
      int x0, y0, x1, y1, bottom, rf, rl;
      s = NO_SPAN;
      if (r.opcode == OP_LOAD) begin
         x0 = int'($signed(r.x_start));
         y0 = int'($signed(r.y_start));
         x1 = int'($signed(r.x_end));
         y1 = int'($signed(r.y_end));
         x_backward = !(x1 > x0);
         y_backward = !(y1 > y0);
         run_x = (x1 > x0) ? x1 - x0 : x0 - x1;
         run_y = (y1 > y0) ? y1 - y0 : y0 - y1;
         x_major = run_x >= run_y;
         err_acc = x_major ? -run_x : -run_y;
         pixels_left = (x_major ? run_x : run_y) + 1;
         pos_x = x0;
         pos_y = y0;
         line_color = r.draw_color;
         line_live = 1'b1;
         return 1'b0;
      end
      if (!line_live || pixels_left == 0) begin
         line_live = 1'b0;
         s.line_done = 1'b1;
         return 1'b1;
      end
      bottom = pos_y + cfg_thickness - 1;
      rf = (pos_y < 0) ? 0 : pos_y;
      rl = (bottom > cfg_height - 1) ? cfg_height - 1 : bottom;
      if (cfg_thickness != 0 && pos_x >= 0 && pos_x < cfg_width && rf <= rl) begin
         s.pixel_x = DIM_BITS'(pos_x);
         s.row_first = DIM_BITS'(rf);
         s.row_last = DIM_BITS'(rl);
         s.first_address = 32'(pos_x) + 32'(rf) * 32'(cfg_stride);
         s.visible = 1'b1;
      end
      s.span_color = line_color;
      s.line_done = (pixels_left == 1);
      if (x_major) begin
         pos_x += x_backward ? -1 : 1;
         err_acc += 2 * run_y;
         if (err_acc >= 0) begin
            pos_y += y_backward ? -1 : 1;
            err_acc -= 2 * run_x;
         end
      end else begin
         pos_y += y_backward ? -1 : 1;
         err_acc += 2 * run_x;
         if (err_acc >= 0) begin
            pos_x += x_backward ? -1 : 1;
            err_acc -= 2 * run_y;
         end
      end
      pixels_left--;
      if (pixels_left == 0)
         line_live = 1'b0;
      return 1'b1;
   endfunction

   task automatic send_stim(input stim_row_type r);
      span_type s;
      int       gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_opcode <= r.opcode;
      req_x_start <= r.x_start;
      req_y_start <= r.y_start;
      req_x_end <= r.x_end;
      req_y_end <= r.y_end;
      req_draw_color <= r.draw_color;
      do @(posedge clock); while (req_stall);
      burst_left--;
      if (rasterize_item(r, s))
         span_queue.push_back(r.typed ? r.want : s);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (span_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // back-to-back APB transfers; caller drops psel after the last one
   task automatic csr_access(input csr_reg_type idx, input bit is_write, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= is_write ? value : '0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (!is_write)
         check_field($sformatf("csr %s readback", idx.name()), csr_prdata, value);
   endtask

   task automatic set_config(input int width, input int height, input int stride, input int thick);
      int vals [4];
      vals = '{width, height, stride, thick};
      for (int i = 0; i < 4; i++) begin
         csr_access(csr_reg_type'(i), 1'b1, 32'(vals[i]));
         csr_access(csr_reg_type'(i), 1'b0, 32'(vals[i]));
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      cfg_width = width;
      cfg_height = height;
      cfg_stride = stride;
      cfg_thickness = thick;
   endtask

   // mostly load + full walk of a short line, some truncated walks, lone steps and loads
   task automatic run_random(input int quota);
      stim_row_type r;
      int           sent, kind, steps, x0, y0, x1, y1, lim_x, lim_y, dx, dy;
      sent = 0;
      while (sent < quota) begin
         kind = $urandom_range(0, 9);
         r = '0;
         r.x_start = 16'($urandom());
         r.y_start = 16'($urandom());
         r.x_end = 16'($urandom());
         r.y_end = 16'($urandom());
         r.draw_color = $urandom();
         if (kind == 0) begin
            r.opcode = OP_STEP;
            send_stim(r);
            sent++;
         end else begin
            r.opcode = OP_LOAD;
            if (kind != 1 && $urandom_range(0, 4) != 0) begin
               lim_x = ((cfg_width > 200) ? 200 : cfg_width) + 16;
               lim_y = ((cfg_height > 200) ? 200 : cfg_height) + 16;
               x0 = int'($urandom_range(0, lim_x)) - 8;
               y0 = int'($urandom_range(0, lim_y)) - 8;
               x1 = x0 + int'($urandom_range(0, 48)) - 24;
               y1 = y0 + int'($urandom_range(0, 48)) - 24;
               r.x_start = 16'(x0);
               r.y_start = 16'(y0);
               r.x_end = 16'(x1);
               r.y_end = 16'(y1);
            end
            send_stim(r);
            sent++;
            if (kind != 1) begin
               x0 = int'($signed(r.x_start));
               x1 = int'($signed(r.x_end));
               y0 = int'($signed(r.y_start));
               y1 = int'($signed(r.y_end));
               dx = (x1 > x0) ? x1 - x0 : x0 - x1;
               dy = (y1 > y0) ? y1 - y0 : y0 - y1;
               steps = ((dx > dy) ? dx : dy) + 1 + $urandom_range(0, 2);
               if (steps > 40)
                  steps = $urandom_range(1, 40);
               if ($urandom_range(0, 5) == 0)
                  steps = $urandom_range(0, steps);
               r.opcode = OP_STEP;
               repeat (steps) begin
                  r.x_start = 16'($urandom());
                  r.y_end = 16'($urandom());
                  r.draw_color = $urandom();
                  send_stim(r);
                  sent++;
               end
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_hold == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            stall_hold = $urandom_range(4, 64);
         end
         stall_hold--;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
            default:     rsp_stall <= stall_hold[1];
         endcase
      end
   end

   always @(posedge clock) begin : span_monitor
      span_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_pixel_x, rsp_row_first, rsp_row_last, rsp_first_address,
                 rsp_span_color, rsp_visible, rsp_line_done};
         if (span_queue.size() == 0) begin
            report_mismatch("span transaction with nothing pending");
         end else begin
            want = span_queue.pop_front();
            check_field("pixel_x", 32'(got.pixel_x), 32'(want.pixel_x));
            check_field("row_first", 32'(got.row_first), 32'(want.row_first));
            check_field("row_last", 32'(got.row_last), 32'(want.row_last));
            check_field("first_address", got.first_address, want.first_address);
            check_field("span_color", got.span_color, want.span_color);
            check_field("visible", 32'(got.visible), 32'(want.visible));
            check_field("line_done", 32'(got.line_done), 32'(want.line_done));
         end
      end
   end

   initial begin
      int rst_vals [4];
      rst_vals = '{1920, 1080, 1920, 1};
      directed_rows = '{
         // step with no line loaded
         '{OP_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b1, DONE_ONLY},
         // single-pixel line, then step past its end
         '{OP_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'hDEADBEEF, 1'b0, NO_SPAN},
         '{OP_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b1,
           '{15'd0, 15'd0, 15'd0, 32'd0, 32'hDEADBEEF, 1'b1, 1'b1}},
         '{OP_STEP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b1, DONE_ONLY},
         // coordinate extremes, both directions
         '{OP_LOAD, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 32'hFFFFFFFF, 1'b0, NO_SPAN},
         '{OP_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b1,
           '{15'd0, 15'd0, 15'd0, 32'd0, 32'hFFFFFFFF, 1'b0, 1'b0}},
         '{OP_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b0, NO_SPAN},
         '{OP_LOAD, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 32'h00000000, 1'b0, NO_SPAN},
         '{OP_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b1,
           '{15'd0, 15'd0, 15'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
         // bottom-right corner of the default frame, then off the right edge
         '{OP_LOAD, 16'd1919, 16'd1079, 16'd1925, 16'd1079, 32'h01020304, 1'b0, NO_SPAN},
         '{OP_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b1,
           '{15'd1919, 15'd1079, 15'd1079, 32'd2073599, 32'h01020304, 1'b1, 1'b0}},
         '{OP_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b0, NO_SPAN},
         // steep line going up and left
         '{OP_LOAD, 16'd5, 16'd10, 16'd3, 16'd2, 32'h11223344, 1'b0, NO_SPAN},
         '{OP_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b0, NO_SPAN},
         '{OP_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b0, NO_SPAN},
         '{OP_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b0, NO_SPAN},
         // rows above the frame
         '{OP_LOAD, 16'd10, 16'hFFFD, 16'd20, 16'd0, 32'hA5A5A5A5, 1'b0, NO_SPAN},
         '{OP_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b0, NO_SPAN},
         '{OP_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b0, NO_SPAN},
         // reload in the middle of a line, equal deltas
         '{OP_LOAD, 16'd100, 16'd100, 16'd110, 16'd105, 32'h5A5A5A5A, 1'b0, NO_SPAN},
         '{OP_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b0, NO_SPAN},
         '{OP_LOAD, 16'd2, 16'd2, 16'd0, 16'd0, 32'hC3C3C3C3, 1'b0, NO_SPAN},
         '{OP_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b0, NO_SPAN},
         '{OP_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b0, NO_SPAN},
         '{OP_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b0, NO_SPAN},
         '{OP_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b1, DONE_ONLY}
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 4; i++)
         csr_access(csr_reg_type'(i), 1'b0, 32'(rst_vals[i]));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      foreach (directed_rows[i])
         send_stim(directed_rows[i]);
      drain();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < FIXED_PHASES)
            set_config(fixed_cfg[p][0], fixed_cfg[p][1], fixed_cfg[p][2], fixed_cfg[p][3]);
         else
            set_config($urandom_range(1, 128), $urandom_range(1, 96),
                       $urandom_range(0, 65535), $urandom_range(0, 12));
         run_random(RANDOM_PER_PHASE);
         drain();
      end
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: thick_line_rasterizer_core.f
+incdir+hw/rtl
hw/rtl/tlr_pkg.sv
hw/rtl/thick_line_rasterizer_core.sv
sim/thick_line_rasterizer_core_tb.sv
